>>> rtl/qkd_pkg.sv
`default_nettype none
package qkd_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF     = 32;

  localparam int unsigned NOW_W   = 32;
  localparam int unsigned STEP_W  = 8;
  localparam int unsigned KNOB_W  = 16;
  localparam int unsigned MAG_W   = 7;
  localparam int unsigned MS8_W   = 8;
  localparam int unsigned CLICK_W = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0]         LATCH_AB            = 2'b11;
  localparam logic               ACCEL_ENABLE_RST    = 1'b1;
  localparam logic [MS8_W-1:0]   DETENT_DEBOUNCE_RST = 8'd5;
  localparam logic [MS8_W-1:0]   FAST_WINDOW_RST     = 8'd25;
  localparam logic [MAG_W-1:0]   ACCEL_STEP_RST      = 7'd10;
  localparam logic [CLICK_W-1:0] CLICK_DEBOUNCE_RST  = 16'd200;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_CW,
    EV_CW_ACCEL,
    EV_CCW,
    EV_CCW_ACCEL
  } event_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_ENABLE,
    CFG_DETENT_DEBOUNCE,
    CFG_FAST_WINDOW,
    CFG_ACCEL_STEP,
    CFG_CLICK_DEBOUNCE
  } cfg_index_t;

  // Quarter-step move for a transition, indexed by {old AB, new AB}.
  function automatic logic signed [1:0] quad_move(input logic [3:0] trans);
    logic signed [1:0] move;
    case (trans)
      4'd1, 4'd7, 4'd8, 4'd14: move = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: move = 2'sd1;
      default: move = 2'sd0;
    endcase
    return move;
  endfunction

endpackage
`default_nettype wire

>>> rtl/qkd_if.sv
`default_nettype none
interface qkd_sample_if;
  import qkd_pkg::*;

  logic             valid;
  logic             ready;
  logic             line_a;
  logic             line_b;
  logic             button_level;
  logic [NOW_W-1:0] now_ms;

  modport source (output valid, line_a, line_b, button_level, now_ms, input ready);
  modport sink   (input valid, line_a, line_b, button_level, now_ms, output ready);
endinterface

interface qkd_result_if;
  import qkd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [STEP_W-1:0] step;
  event_code_t              event_code;
  logic                     click;
  logic signed [KNOB_W-1:0] knob_position;

  modport source (output valid, step, event_code, click, knob_position, input ready);
  modport sink   (input valid, step, event_code, click, knob_position, output ready);
endinterface
`default_nettype wire

>>> rtl/quadrature_knob_decoder_accel_top.sv
`default_nettype none
// A sample beat passes through the input register and then the result register.
// Throughput: one sample per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (rst, synchronous) empties both registers, returns the registers to
// their defaults and the decoder to the latch state with zero position and time.
module quadrature_knob_decoder_accel_top #(
  parameter int unsigned POSITION_WIDTH = qkd_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH     = qkd_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  qkd_sample_if.sink                          sample,
  qkd_result_if.source                        result,
  input  wire logic                           cfg_we,
  input  wire logic [qkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [qkd_pkg::CFG_W-1:0]      cfg_data
);
  import qkd_pkg::*;

  localparam int unsigned IDX_W = POSITION_WIDTH - 2;

  // Configuration registers.
  logic                accel_enable;
  logic [MS8_W-1:0]    detent_debounce_ms;
  logic [MS8_W-1:0]    fast_window_ms;
  logic [MAG_W-1:0]    accel_step;
  logic [CLICK_W-1:0]  click_debounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_enable       <= ACCEL_ENABLE_RST;
      detent_debounce_ms <= DETENT_DEBOUNCE_RST;
      fast_window_ms     <= FAST_WINDOW_RST;
      accel_step         <= ACCEL_STEP_RST;
      click_debounce_ms  <= CLICK_DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_ACCEL_ENABLE:    accel_enable       <= cfg_data[0];
        CFG_DETENT_DEBOUNCE: detent_debounce_ms <= cfg_data[MS8_W-1:0];
        CFG_FAST_WINDOW:     fast_window_ms     <= cfg_data[MS8_W-1:0];
        CFG_ACCEL_STEP:      accel_step         <= cfg_data[MAG_W-1:0];
        CFG_CLICK_DEBOUNCE:  click_debounce_ms  <= cfg_data[CLICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic                  s1_valid;
  logic [1:0]            s1_ab;
  logic                  s1_level;
  logic [TIME_WIDTH-1:0] s1_now;

  logic out_open;
  logic s1_fire;

  assign out_open     = !result.valid || result.ready;
  assign s1_fire      = s1_valid && out_open;
  assign sample.ready = !s1_valid || out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      s1_ab    <= {sample.line_b, sample.line_a};
      s1_level <= sample.button_level;
      s1_now   <= sample.now_ms[TIME_WIDTH-1:0];
    end
  end

  // Decoder state.
  logic [1:0]                prev_ab, prev_ab_next;
  logic [POSITION_WIDTH-1:0] quarter_position, quarter_position_next;
  logic [IDX_W-1:0]          last_detent_index, last_detent_index_next;
  logic [TIME_WIDTH-1:0]     last_detent_time, last_detent_time_next;
  logic [KNOB_W-1:0]         knob_total, knob_total_next;
  logic [TIME_WIDTH-1:0]     last_click_time, last_click_time_next;
  logic                      last_button_level, last_button_level_next;

  logic signed [1:0]     move;
  logic [TIME_WIDTH-1:0] detent_dt;
  logic [TIME_WIDTH-1:0] click_dt;
  logic                  detent_ok;
  logic [MAG_W-1:0]      mag;
  logic                  ccw;
  logic [STEP_W-1:0]     step_next;
  event_code_t           code_next;
  logic                  click_next;

  always_comb begin
    prev_ab_next           = prev_ab;
    quarter_position_next  = quarter_position;
    last_detent_index_next = last_detent_index;
    last_detent_time_next  = last_detent_time;
    knob_total_next        = knob_total;
    last_click_time_next   = last_click_time;
    last_button_level_next = last_button_level;
    step_next              = '0;
    code_next              = EV_NONE;
    click_next             = 1'b0;
    detent_ok              = 1'b0;

    move      = quad_move({prev_ab, s1_ab});
    ccw       = move[1];
    detent_dt = s1_now - last_detent_time;
    click_dt  = s1_now - last_click_time;
    mag       = (detent_dt < {{(TIME_WIDTH-MS8_W){1'b0}}, fast_window_ms} && accel_enable)
                ? accel_step : MAG_W'(1);

    if (s1_ab != prev_ab) begin
      quarter_position_next = quarter_position
                              + {{(POSITION_WIDTH-2){move[1]}}, move};
      prev_ab_next = s1_ab;
      if (s1_ab == LATCH_AB &&
          quarter_position_next[POSITION_WIDTH-1:2] != last_detent_index) begin
        last_detent_index_next = quarter_position_next[POSITION_WIDTH-1:2];
        if (detent_dt > {{(TIME_WIDTH-MS8_W){1'b0}}, detent_debounce_ms}) begin
          detent_ok             = 1'b1;
          last_detent_time_next = s1_now;
          if (ccw) begin
            step_next       = STEP_W'(0) - {{(STEP_W-MAG_W){1'b0}}, mag};
            knob_total_next = knob_total - {{(KNOB_W-MAG_W){1'b0}}, mag};
            code_next       = (mag == MAG_W'(1)) ? EV_CCW : EV_CCW_ACCEL;
          end else begin
            step_next       = {{(STEP_W-MAG_W){1'b0}}, mag};
            knob_total_next = knob_total + {{(KNOB_W-MAG_W){1'b0}}, mag};
            code_next       = (mag == MAG_W'(1)) ? EV_CW : EV_CW_ACCEL;
          end
        end
      end
    end

    // A release outside the window is recorded but does not restart it.
    if (s1_level != last_button_level &&
        click_dt > {{(TIME_WIDTH-CLICK_W){1'b0}}, click_debounce_ms}) begin
      last_button_level_next = s1_level;
      if (!s1_level) begin
        click_next           = 1'b1;
        last_click_time_next = s1_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab           <= LATCH_AB;
      quarter_position  <= '0;
      last_detent_index <= '0;
      last_detent_time  <= '0;
      knob_total        <= '0;
      last_click_time   <= '0;
      last_button_level <= 1'b1;
    end else if (s1_fire) begin
      prev_ab           <= prev_ab_next;
      quarter_position  <= quarter_position_next;
      last_detent_index <= last_detent_index_next;
      last_detent_time  <= last_detent_time_next;
      knob_total        <= knob_total_next;
      last_click_time   <= last_click_time_next;
      last_button_level <= last_button_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_open) begin
      result.valid <= s1_valid;
    end
    if (s1_fire) begin
      result.step          <= step_next;
      result.event_code    <= code_next;
      result.click         <= click_next;
      result.knob_position <= knob_total_next;
    end
  end

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !s1_valid && !result.valid)
    else $error("pipeline not empty after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample side stalled with an empty result register");

  a_plain_step: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.event_code == EV_CW || result.event_code == EV_CCW)
    |-> result.step == 8'sd1 || result.step == -8'sd1)
    else $error("plain detent reported with a step other than one");

  a_total_holds: assert property (@(posedge clk) disable iff (rst)
    s1_fire && !detent_ok |=> $stable(knob_total))
    else $error("knob position moved without an accepted detent");

endmodule
`default_nettype wire

>>> dv/testbench.sv
module testbench;
  import qkd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_UNMAPPED = 3'd6;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int DRAIN_LIMIT = 5000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic             line_a;
    logic             line_b;
    logic             button_level;
    logic [NOW_W-1:0] now_ms;
  } knob_sample_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    event_code_t              event_code;
    logic                     click;
    logic signed [KNOB_W-1:0] knob_position;
  } knob_result_t;

  // Position of an AB pair along the clockwise cycle 11 -> 01 -> 00 -> 10.
  function automatic int ab_phase(logic [1:0] ab);
    case (ab)
      2'b11: return 0;
      2'b01: return 1;
      2'b00: return 2;
      default: return 3;
    endcase
  endfunction

  function automatic logic [1:0] phase_ab(int p);
    case (p & 3)
      0: return 2'b11;
      1: return 2'b01;
      2: return 2'b00;
      default: return 2'b10;
    endcase
  endfunction

  // One quarter forward is +1, one back is -1; a skipped state moves nothing.
  function automatic int quarter_move(logic [1:0] from_ab, logic [1:0] to_ab);
    int d;
    d = (ab_phase(to_ab) - ab_phase(from_ab)) & 3;
    if (d == 1) return 1;
    if (d == 3) return -1;
    return 0;
  endfunction

  class knob_scoreboard;
    logic                accel_on;
    logic [MS8_W-1:0]    detent_gap;
    logic [MS8_W-1:0]    fast_gap;
    logic [MAG_W-1:0]    accel_mag;
    logic [CLICK_W-1:0]  click_gap;

    logic [1:0]          last_ab;
    logic [15:0]         quarters;
    logic [13:0]         detent_index;
    logic [NOW_W-1:0]    detent_time;
    logic [KNOB_W-1:0]   position;
    logic [NOW_W-1:0]    click_time;
    logic                button_was;

    knob_result_t expected_results[$];
    int errors;

    function new();
      accel_on = ACCEL_ENABLE_RST;
      detent_gap = DETENT_DEBOUNCE_RST;
      fast_gap = FAST_WINDOW_RST;
      accel_mag = ACCEL_STEP_RST;
      click_gap = CLICK_DEBOUNCE_RST;
      last_ab = LATCH_AB;
      quarters = '0;
      detent_index = '0;
      detent_time = '0;
      position = '0;
      click_time = '0;
      button_was = 1'b1;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_ACCEL_ENABLE:    accel_on = value[0];
        CFG_DETENT_DEBOUNCE: detent_gap = value[MS8_W-1:0];
        CFG_FAST_WINDOW:     fast_gap = value[MS8_W-1:0];
        CFG_ACCEL_STEP:      accel_mag = value[MAG_W-1:0];
        CFG_CLICK_DEBOUNCE:  click_gap = value[CLICK_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(knob_sample_t s);
      logic [1:0]       ab;
      int               move;
      logic [13:0]      idx;
      logic [NOW_W-1:0] dt;
      logic [MAG_W-1:0] mag;
      knob_result_t     r;
      ab = {s.line_b, s.line_a};
      r.step = '0;
      r.event_code = EV_NONE;
      r.click = 1'b0;
      if (ab != last_ab) begin
        move = quarter_move(last_ab, ab);
        quarters = quarters + 16'(move);
        if (ab == LATCH_AB) begin
          idx = quarters[15:2];
          if (idx != detent_index) begin
            // The index is taken even when the detent itself is debounced away.
            detent_index = idx;
            dt = s.now_ms - detent_time;
            if (dt > 32'(detent_gap)) begin
              mag = 7'd1;
              if (dt < 32'(fast_gap) && accel_on) mag = accel_mag;
              if (move < 0) begin
                r.step = 8'd0 - {1'b0, mag};
                position = position - 16'(mag);
                r.event_code = (mag == 7'd1) ? EV_CCW : EV_CCW_ACCEL;
              end else begin
                r.step = {1'b0, mag};
                position = position + 16'(mag);
                r.event_code = (mag == 7'd1) ? EV_CW : EV_CW_ACCEL;
              end
              detent_time = s.now_ms;
            end
          end
        end
        last_ab = ab;
      end
      // A release outside the window is taken but does not restart the window.
      if (s.button_level != button_was && (s.now_ms - click_time) > 32'(click_gap)) begin
        if (!s.button_level) begin
          r.click = 1'b1;
          click_time = s.now_ms;
        end
        button_was = s.button_level;
      end
      r.knob_position = position;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_LIMIT) $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(knob_result_t got);
      knob_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result beat with no sample pending: step %0d code %0d",
                                  got.step, got.event_code));
        return;
      end
      want = expected_results.pop_front();
      if (got.step !== want.step)
        report_mismatch($sformatf("step %0d, want %0d", got.step, want.step));
      if (got.event_code !== want.event_code)
        report_mismatch($sformatf("event_code %0d, want %0d", got.event_code,
                                  want.event_code));
      if (got.click !== want.click)
        report_mismatch($sformatf("click %0b, want %0b", got.click, want.click));
      if (got.knob_position !== want.knob_position)
        report_mismatch($sformatf("knob_position %0d, want %0d", got.knob_position,
                                  want.knob_position));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  qkd_sample_if sample_bus();
  qkd_result_if result_bus();

  quadrature_knob_decoder_accel_top DUT (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  knob_scoreboard sb;

  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  bit holdoff_request = 1'b0;
  int holdoff_left = 0;
  int samples_sent = 0;

  logic [1:0]       cur_ab = LATCH_AB;
  logic             btn_level = 1'b1;
  logic [NOW_W-1:0] t_now = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (holdoff_left > 0) begin
      result_bus.ready <= 1'b0;
      holdoff_left = holdoff_left - 1;
    end else if (holdoff_request) begin
      holdoff_request = 1'b0;
      holdoff_left = HOLDOFF_CYCLES - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watch
    knob_sample_t beat;
    knob_result_t got;
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready) begin
        beat.line_a = sample_bus.line_a;
        beat.line_b = sample_bus.line_b;
        beat.button_level = sample_bus.button_level;
        beat.now_ms = sample_bus.now_ms;
        sb.note_sample(beat);
      end
      if (result_bus.valid && result_bus.ready) begin
        got.step = result_bus.step;
        got.event_code = result_bus.event_code;
        got.click = result_bus.click;
        got.knob_position = result_bus.knob_position;
        sb.check_result(got);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_sample(logic [1:0] ab, logic btn, logic [NOW_W-1:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.line_a <= ab[0];
    sample_bus.line_b <= ab[1];
    sample_bus.button_level <= btn;
    sample_bus.now_ms <= now;
    do @(posedge clk); while (!sample_bus.ready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic feed(logic [1:0] ab, logic btn, logic [NOW_W-1:0] now);
    cur_ab = ab;
    btn_level = btn;
    t_now = now;
    offer_sample(ab, btn, now);
  endtask

  task automatic random_feed(logic [1:0] ab, logic [NOW_W-1:0] gap);
    if ($urandom_range(99) < 15) btn_level = ~btn_level;
    feed(ab, btn_level, t_now + gap);
  endtask

  // Mostly near the debounce and acceleration thresholds, now and then a wide jump.
  function automatic logic [NOW_W-1:0] landing_gap();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(30);
      4, 5: return 32'(sb.detent_gap) + $urandom_range(2) - 1;
      6: return 32'(sb.fast_gap) + $urandom_range(2) - 1;
      7, 8: return $urandom_range(400);
      default: return $urandom;
    endcase
  endfunction

  task automatic turn_detent(bit cw, logic [NOW_W-1:0] gap);
    int p;
    p = ab_phase(cur_ab);
    do begin
      p = cw ? p + 1 : p + 3;
      if (phase_ab(p) == LATCH_AB) random_feed(phase_ab(p), gap);
      else random_feed(phase_ab(p), $urandom_range(3));
    end while (phase_ab(p) != LATCH_AB);
  endtask

  task automatic random_stretch(int count);
    int target;
    int pick;
    int p;
    target = samples_sent + count;
    while (samples_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        turn_detent(1'($urandom_range(1)), landing_gap());
      end else if (pick < 85) begin
        // Contact bounce: one quarter out, then a skipped state to the neighbour on the other side.
        p = ab_phase(cur_ab) + ($urandom_range(1) ? 1 : 3);
        random_feed(phase_ab(p), $urandom_range(3));
        random_feed(phase_ab(p + 2), $urandom_range(3));
      end else begin
        random_feed(2'($urandom_range(3)), landing_gap());
      end
    end
  endtask

  // Called at a falling edge while the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Upper data bits beyond each register's width carry junk that must be dropped.
  task automatic configure(logic accel, logic [MS8_W-1:0] det, logic [MS8_W-1:0] fast,
                           logic [MAG_W-1:0] mag, logic [CLICK_W-1:0] click_ms);
    write_reg(CFG_ACCEL_ENABLE, {15'($urandom), accel});
    write_reg(CFG_DETENT_DEBOUNCE, {8'($urandom), det});
    write_reg(CFG_INDEX_UNMAPPED, 16'($urandom));
    write_reg(CFG_FAST_WINDOW, {8'($urandom), fast});
    write_reg(CFG_ACCEL_STEP, {9'($urandom), mag});
    write_reg(CFG_CLICK_DEBOUNCE, click_ms);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    sample_bus.valid <= 1'b0;
    while (sb.expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.line_a = 1'b1;
    sample_bus.line_b = 1'b1;
    sample_bus.button_level = 1'b1;
    sample_bus.now_ms = '0;
    result_bus.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings. A quick first detent is accelerated.
    feed(2'b01, 1'b1, 1);
    feed(2'b00, 1'b1, 2);
    feed(2'b10, 1'b1, 3);
    feed(2'b11, 1'b1, 6);
    // Landing exactly at the detent debounce time is dropped.
    feed(2'b01, 1'b1, 8);
    feed(2'b00, 1'b1, 9);
    feed(2'b10, 1'b1, 10);
    feed(2'b11, 1'b1, 11);
    // Counter clockwise, exactly at the fast window: plain step.
    feed(2'b10, 1'b1, 20);
    feed(2'b00, 1'b1, 25);
    feed(2'b01, 1'b1, 30);
    feed(2'b11, 1'b1, 31);
    // Landing on the latch by a skipped state counts as clockwise.
    feed(2'b10, 1'b1, 100);
    feed(2'b00, 1'b1, 110);
    feed(2'b11, 1'b1, 131);
    // Press at the click window edge, just past it, early and late release.
    feed(2'b11, 1'b0, 200);
    feed(2'b11, 1'b0, 201);
    feed(2'b11, 1'b1, 202);
    feed(2'b11, 1'b1, 402);
    feed(2'b11, 1'b0, 403);
    // Detents across the wrap of the millisecond counter.
    feed(2'b01, 1'b1, 32'hFFFF_FFF0);
    feed(2'b00, 1'b1, 32'hFFFF_FFF1);
    feed(2'b10, 1'b1, 32'hFFFF_FFF2);
    feed(2'b11, 1'b1, 32'hFFFF_FFF4);
    feed(2'b01, 1'b1, 32'h0000_0000);
    feed(2'b00, 1'b1, 32'h0000_0001);
    feed(2'b10, 1'b1, 32'h0000_0002);
    feed(2'b11, 1'b1, 32'h0000_0003);
    drain();

    configure(1'b0, 8'd0, 8'd255, 7'd127, 16'd0);
    // The result side stalls for a long stretch so the block backs up.
    holdoff_request = 1'b1;
    random_stretch(100);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    configure(1'b1, 8'd255, 8'd255, 7'd1, 16'hFFFF);
    random_stretch(100);
    drain();
    tx_idle_pct = 30;
    rx_idle_pct = 30;

    // Accelerated step of zero is out of range but still has defined behavior.
    configure(1'b1, 8'd2, 8'd40, 7'd0, 16'd10);
    random_stretch(100);
    drain();

    configure(1'($urandom_range(1)), 8'($urandom_range(20)), 8'($urandom_range(60)),
              7'($urandom_range(1, 127)), 16'($urandom_range(300)));
    random_stretch(120);
    drain();

    // Fast spin with the largest step.
    configure(1'b1, 8'd0, 8'd255, 7'd127, 16'($urandom_range(100)));
    repeat (15) turn_detent(1'b1, $urandom_range(1, 20));
    drain();

    if (sb.expected_results.size() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived",
                                   sb.expected_results.size()));
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
